// File: design/imm_pkg.sv
// shared types, constants and register indexes for the int8 matrix multiply
package imm_pkg;

   localparam int MAX_COLUMNS_DEF = 16;
   localparam int MAX_LENGTH_DEF  = 256;
   localparam int RESULT_LIMIT    = 16;

   localparam int VAL_W      = 8;
   localparam int PROD_W     = 16;
   localparam int SUM_W      = 24;
   localparam int COL_W      = 4;
   localparam int POS_W      = 8;
   localparam int K_LEN_W    = 9;
   localparam int C_LEN_W    = 5;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 9;

   localparam logic [CSR_IDX_W-1:0] CSR_K_LEN = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_C_LEN = 1'b1;

   localparam logic [K_LEN_W-1:0] K_LEN_RST = 9'd256;
   localparam logic [C_LEN_W-1:0] C_LEN_RST = 5'd16;

   localparam logic KIND_WEIGHT = 1'b0;
   localparam logic KIND_ACT    = 1'b1;

   typedef struct packed {
      logic                    kind;
      logic [COL_W-1:0]        column;
      logic [POS_W-1:0]        position;
      logic signed [VAL_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [COL_W-1:0]        out_column;
      logic signed [SUM_W-1:0] dot_sum;
      logic                    row_last;
   } rsp_type;

   // control for the multiply-accumulate stage, aligned with memory read data
   typedef struct packed {
      logic valid;
      logic first;
   } mac_ctl_type;

endpackage

// File: design/imm_ram.sv
// simple dual-port memory, one write port and one registered read port
module imm_ram #(
   parameter int DEPTH = 256,
   parameter int AW    = 8,
   parameter int DW    = 8
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/imm_mac.sv
// signed 8x8 multiply with a wrapping 24-bit accumulator
module imm_mac (
   input  logic                            clock,
   input  imm_pkg::mac_ctl_type            ctl,
   input  logic signed [imm_pkg::VAL_W-1:0] act,
   input  logic signed [imm_pkg::VAL_W-1:0] wgt,
   output logic signed [imm_pkg::SUM_W-1:0] acc
);

   logic signed [imm_pkg::PROD_W-1:0] prod;
   logic signed [imm_pkg::SUM_W-1:0]  acc_ff;
   logic signed [imm_pkg::SUM_W-1:0]  acc_in;

   assign prod = act * wgt;

   // first product of a column restarts the sum
   assign acc_in = (ctl.first ? '0 : acc_ff) + imm_pkg::SUM_W'(prod);

   always_ff @(posedge clock) begin
      if (ctl.valid) begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

// File: design/int8_matrix_multiply.sv
// top level: int8 matrix multiply with weight store, row buffer and one shared mac
// a weight transaction or a non-final activation is accepted while idle; a row-closing
//   activation holds req_ready low while the single mac works through all c_eff columns,
//   and longer while the output register is full; no new request is taken until the last
//   column sum has been handed to the output register
// reset: synchronous, clears the fill counter, state machine, mac control and output valid,
//   restores k_len = 256, c_len = 16; the memories are not cleared
module int8_matrix_multiply #(
   parameter int MAX_COLUMNS = imm_pkg::MAX_COLUMNS_DEF,
   parameter int MAX_LENGTH  = imm_pkg::MAX_LENGTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  imm_pkg::req_type                  req_data,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output imm_pkg::rsp_type                  rsp_data,
   // configuration writes
   input  logic                              csr_we,
   input  logic [imm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [imm_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   // memory geometry
   localparam int W_DEPTH = MAX_COLUMNS * MAX_LENGTH;
   localparam int W_AW    = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;
   localparam int R_AW    = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
   // results per row can not exceed the column count or the result limit
   localparam int C_MAX   = (MAX_COLUMNS < imm_pkg::RESULT_LIMIT) ?
                            MAX_COLUMNS : imm_pkg::RESULT_LIMIT;

   localparam int KW = imm_pkg::K_LEN_W;
   localparam int CW = imm_pkg::COL_W;

   // sequencer states
   localparam logic [1:0] ST_IDLE = 2'd0;  // taking transactions
   localparam logic [1:0] ST_RUN  = 2'd1;  // issuing reads for one column
   localparam logic [1:0] ST_WAIT = 2'd2;  // last product entering the accumulator
   localparam logic [1:0] ST_EMIT = 2'd3;  // handing the column sum to the output register

   logic [1:0]                   state_ff, state_in;
   logic [KW-1:0]                fill_ff, fill_in;
   logic [KW-1:0]                k_len_ff, k_len_in;
   logic [imm_pkg::C_LEN_W-1:0]  c_len_ff, c_len_in;
   logic [KW-1:0]                k_last_ff, k_last_in;
   logic [CW-1:0]                c_last_ff, c_last_in;
   logic [KW-1:0]                i_ff, i_in;
   logic [CW-1:0]                j_ff, j_in;
   logic [W_AW-1:0]              base_ff, base_in;
   imm_pkg::mac_ctl_type         ctl_ff, ctl_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   imm_pkg::rsp_type             rsp_data_ff, rsp_data_in;

   logic                         req_fire;
   logic                         is_act;
   logic [KW-1:0]                fill_nx;
   logic [KW-1:0]                k_eff;
   logic [imm_pkg::C_LEN_W-1:0]  c_eff;
   logic                         row_done;
   logic                         out_free;

   logic                         w_wr_en;
   logic [W_AW-1:0]              w_wr_addr;
   logic                         r_wr_en;
   logic [R_AW-1:0]              r_wr_addr;
   logic                         rd_en;
   logic [W_AW-1:0]              w_rd_addr;
   logic [R_AW-1:0]              r_rd_addr;
   logic [imm_pkg::VAL_W-1:0]    w_rd_data;
   logic [imm_pkg::VAL_W-1:0]    r_rd_data;
   logic signed [imm_pkg::SUM_W-1:0] acc;

   // only idle takes transactions, so writes never meet the compute reads
   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid & req_ready;
   assign is_act    = (req_data.kind == imm_pkg::KIND_ACT);
   assign fill_nx   = fill_ff + KW'(1);

   // effective row length: zero acts as one, clamp to the buffer depth
   always_comb begin
      if (k_len_ff == '0) begin
         k_eff = KW'(1);
      end else if (32'(k_len_ff) > MAX_LENGTH) begin
         k_eff = KW'(MAX_LENGTH);
      end else begin
         k_eff = k_len_ff;
      end
   end

   // effective column count: zero acts as one, clamp to columns in hardware and the result limit
   always_comb begin
      if (c_len_ff == '0) begin
         c_eff = imm_pkg::C_LEN_W'(1);
      end else if (32'(c_len_ff) > C_MAX) begin
         c_eff = imm_pkg::C_LEN_W'(C_MAX);
      end else begin
         c_eff = c_len_ff;
      end
   end

   assign row_done = req_fire & is_act & (fill_nx >= k_eff);

   // weight writes outside the store are dropped
   assign w_wr_en   = req_fire & ~is_act &
                      (32'(req_data.column) < MAX_COLUMNS) &
                      (32'(req_data.position) < MAX_LENGTH);
   assign w_wr_addr = W_AW'(32'(req_data.column) * 32'(MAX_LENGTH) +
                            32'(req_data.position));

   // activation beyond the buffer depth is counted but not stored
   assign r_wr_en   = req_fire & is_act & (32'(fill_ff) < MAX_LENGTH);
   assign r_wr_addr = R_AW'(fill_ff);

   // read side walks element i of column j
   assign rd_en     = (state_ff == ST_RUN);
   assign w_rd_addr = base_ff + W_AW'(i_ff);
   assign r_rd_addr = R_AW'(i_ff);

   assign out_free  = ~rsp_valid_ff | rsp_ready;

   imm_ram #(
      .DEPTH (W_DEPTH),
      .AW    (W_AW),
      .DW    (imm_pkg::VAL_W)
   ) u_weight_store (
      .clock   (clock),
      .wr_en   (w_wr_en),
      .wr_addr (w_wr_addr),
      .wr_data (req_data.value),
      .rd_en   (rd_en),
      .rd_addr (w_rd_addr),
      .rd_data (w_rd_data)
   );

   imm_ram #(
      .DEPTH (MAX_LENGTH),
      .AW    (R_AW),
      .DW    (imm_pkg::VAL_W)
   ) u_row_buffer (
      .clock   (clock),
      .wr_en   (r_wr_en),
      .wr_addr (r_wr_addr),
      .wr_data (req_data.value),
      .rd_en   (rd_en),
      .rd_addr (r_rd_addr),
      .rd_data (r_rd_data)
   );

   imm_mac u_mac (
      .clock (clock),
      .ctl   (ctl_ff),
      .act   (r_rd_data),
      .wgt   (w_rd_data),
      .acc   (acc)
   );

   // sequencer next state
   always_comb begin
      state_in  = state_ff;
      fill_in   = fill_ff;
      k_last_in = k_last_ff;
      c_last_in = c_last_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      base_in   = base_ff;
      case (state_ff)
         ST_IDLE: begin
            if (row_done) begin
               // row complete: latch the sizes and start with column zero
               state_in  = ST_RUN;
               fill_in   = '0;
               k_last_in = k_eff - KW'(1);
               c_last_in = CW'(c_eff - imm_pkg::C_LEN_W'(1));
               i_in      = '0;
               j_in      = '0;
               base_in   = '0;
            end else if (req_fire & is_act) begin
               fill_in = fill_nx;
            end
         end
         ST_RUN: begin
            i_in = i_ff + KW'(1);
            if (i_ff == k_last_ff) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            // hold here while the previous result still waits in the output register
            if (out_free) begin
               if (j_ff == c_last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_RUN;
                  j_in     = j_ff + CW'(1);
                  i_in     = '0;
                  base_in  = base_ff + W_AW'(MAX_LENGTH);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // mac control is registered like the read, so it lines up with the registered read data
   always_comb begin
      ctl_in.valid = (state_ff == ST_RUN);
      ctl_in.first = (i_ff == '0);
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if ((state_ff == ST_EMIT) && out_free) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.out_column = j_ff;
         rsp_data_in.dot_sum    = acc;
         rsp_data_in.row_last   = (j_ff == c_last_ff);
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // configuration registers
   always_comb begin
      k_len_in = k_len_ff;
      c_len_in = c_len_ff;
      if (csr_we) begin
         case (csr_index)
            imm_pkg::CSR_K_LEN: k_len_in = csr_wdata[KW-1:0];
            imm_pkg::CSR_C_LEN: c_len_in = csr_wdata[imm_pkg::C_LEN_W-1:0];
            default: begin
               k_len_in = k_len_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         k_len_ff     <= imm_pkg::K_LEN_RST;
         c_len_ff     <= imm_pkg::C_LEN_RST;
         ctl_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         k_len_ff     <= k_len_in;
         c_len_ff     <= c_len_in;
         ctl_ff       <= ctl_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers, no reset needed
   always_ff @(posedge clock) begin
      k_last_ff   <= k_last_in;
      c_last_ff   <= c_last_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      base_ff     <= base_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // fill counter is parked at zero for the whole compute phase
   a_fill_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (fill_ff == '0))
      else $error("fill counter moved during compute");

   // a product enters the accumulator only in the cycle after a read was issued
   a_mac_after_read: assert property (@(posedge clock) disable iff (reset)
      ctl_ff.valid |-> $past(state_ff == ST_RUN))
      else $error("mac step without a preceding read");

   // emit is reached only once the last product has been accumulated
   a_emit_after_wait: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_EMIT) && ($past(state_ff) != ST_EMIT)) |->
      ($past(state_ff) == ST_WAIT))
      else $error("emit entered before accumulation finished");

   // read index never passes the row length
   a_index_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (i_ff <= k_last_ff))
      else $error("element index past row length");

endmodule

// File: dv/tb_int8_matrix_multiply.sv
// testbench for the int8 matrix multiply: directed table and random phases against a shadow model
module tb_int8_matrix_multiply;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COLS          = imm_pkg::MAX_COLUMNS_DEF;
   localparam int DEPTH         = imm_pkg::MAX_LENGTH_DEF;
   localparam int C_MAX_CODE    = (1 << imm_pkg::C_LEN_W) - 1;
   // leading positions loaded in every column, the longest row used below
   localparam int PRELOAD_LEN   = 12;
   // quiet time after draining, before a register write, with some margin
   localparam int SETTLE_CYCLES = 4;
   localparam int TAIL_CYCLES   = 40;
   localparam int DRAIN_LIMIT   = 50000;
   localparam int HOLD_CYCLES   = 300;
   localparam int NUM_PHASES    = 9;
   localparam int PHASE_ITEMS   = 13;
   localparam int HOLD_PHASE    = 7;
   // watchdog limit in ns, well beyond the slowest run
   localparam longint TIMEOUT_NS = 64'd20_000_000;

   typedef enum logic {STEP_CFG, STEP_ITEM} step_op_type;

   // one row of the directed table: a register write or one request transaction
   typedef struct {
      step_op_type                   op;
      logic [imm_pkg::CSR_IDX_W-1:0]  index;
      logic [imm_pkg::CSR_DATA_W-1:0] wdata;
      imm_pkg::req_type              item;
      bit                            typed;
      imm_pkg::rsp_type              dot;
   } step_type;

   logic                           clock     = 1'b0;
   logic                           reset     = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   imm_pkg::req_type               req_data  = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   imm_pkg::rsp_type               rsp_data;
   logic                           csr_we    = 1'b0;
   logic [imm_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [imm_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   int error_count   = 0;
   int req_idle_pct  = 0;
   int rsp_idle_pct  = 0;
   // bumped by the stimulus to ask the receiver for one long hold-off
   int stall_trigger = 0;
   int stall_seen    = 0;
   int stall_left    = 0;

   imm_pkg::rsp_type expected_dots[$];
   step_type         steps[$];

   // shadow copy of the block state and its two registers
   logic signed [imm_pkg::VAL_W-1:0] shadow_weights [COLS][DEPTH];
   logic signed [imm_pkg::VAL_W-1:0] shadow_row [DEPTH];
   logic [imm_pkg::K_LEN_W-1:0]      shadow_fill;
   logic [imm_pkg::K_LEN_W-1:0]      shadow_k;
   logic [imm_pkg::C_LEN_W-1:0]      shadow_c;

   int8_matrix_multiply dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      $display("ERROR at %0t: %s", $realtime, what);
      error_count++;
   endtask

   // apply one accepted transaction to the shadow state, return the dot products it emits
   task automatic predict_dot_products(input imm_pkg::req_type item,
                                       output imm_pkg::rsp_type dots[$]);
      int               k_eff;
      int               c_eff;
      int               acc;
      imm_pkg::rsp_type dot;
      dots = {};
      if (item.kind == imm_pkg::KIND_WEIGHT) begin
         shadow_weights[item.column][item.position] = item.value;
         return;
      end
      if (shadow_fill < DEPTH) shadow_row[shadow_fill] = item.value;
      shadow_fill = shadow_fill + 1'b1;
      // out-of-range lengths clamp to the supported span
      k_eff = (shadow_k == 0) ? 1 : (shadow_k > DEPTH) ? DEPTH : int'(shadow_k);
      if (shadow_fill < k_eff) return;
      c_eff = (shadow_c == 0) ? 1 : int'(shadow_c);
      if (c_eff > COLS) c_eff = COLS;
      if (c_eff > imm_pkg::RESULT_LIMIT) c_eff = imm_pkg::RESULT_LIMIT;
      for (int j = 0; j < c_eff; j++) begin
         acc = 0;
         for (int i = 0; i < k_eff; i++) begin
            acc += int'(shadow_row[i]) * int'(shadow_weights[j][i]);
         end
         dot.out_column = imm_pkg::COL_W'(j);
         dot.dot_sum    = imm_pkg::SUM_W'(acc);
         dot.row_last   = (j == c_eff - 1);
         dots.push_back(dot);
      end
      shadow_fill = '0;
   endtask

   // offer one transaction after a random gap, hold it until accepted, then predict
   task automatic send_req(input imm_pkg::req_type item, input bit typed = 1'b0,
                           input imm_pkg::rsp_type typed_dot = '0);
      int               gap;
      imm_pkg::rsp_type dots[$];
      gap = 0;
      while ($urandom_range(0, 99) < req_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      predict_dot_products(item, dots);
      // a typed row keeps the shadow in step but queues the hand-written answer
      if (typed) expected_dots.push_back(typed_dot);
      else foreach (dots[i]) expected_dots.push_back(dots[i]);
   endtask

   // stop offering, wait for every outstanding result, let the block go quiet
   task automatic drain_and_settle();
      req_valid <= 1'b0;
      while (expected_dots.size() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [imm_pkg::CSR_IDX_W-1:0] index,
                            input logic [imm_pkg::CSR_DATA_W-1:0] wdata);
      drain_and_settle();
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= wdata;
      if (index == imm_pkg::CSR_K_LEN) shadow_k = wdata[imm_pkg::K_LEN_W-1:0];
      else shadow_c = wdata[imm_pkg::C_LEN_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic imm_pkg::req_type random_req(input int weight_pct);
      imm_pkg::req_type r;
      r.kind     = ($urandom_range(0, 99) < weight_pct) ? imm_pkg::KIND_WEIGHT :
                                                          imm_pkg::KIND_ACT;
      r.column   = imm_pkg::COL_W'($urandom());
      r.position = imm_pkg::POS_W'($urandom());
      r.value    = imm_pkg::VAL_W'($urandom());
      return r;
   endfunction

   function automatic void add_cfg(input logic [imm_pkg::CSR_IDX_W-1:0] index,
                                   input int wdata);
      step_type s;
      s       = '{op: STEP_CFG, default: '0};
      s.index = index;
      s.wdata = imm_pkg::CSR_DATA_W'(wdata);
      steps.push_back(s);
   endfunction

   function automatic void add_item(input logic kind, input int column, input int position,
                                    input int value);
      step_type s;
      s               = '{op: STEP_ITEM, default: '0};
      s.item.kind     = kind;
      s.item.column   = imm_pkg::COL_W'(column);
      s.item.position = imm_pkg::POS_W'(position);
      s.item.value    = imm_pkg::VAL_W'(value);
      steps.push_back(s);
   endfunction

   // activation that closes a single-column row with a sum readable by eye
   function automatic void add_typed(input int value, input int sum);
      add_item(imm_pkg::KIND_ACT, 0, 0, value);
      steps[steps.size()-1].typed          = 1'b1;
      steps[steps.size()-1].dot.out_column = '0;
      steps[steps.size()-1].dot.dot_sum    = imm_pkg::SUM_W'(sum);
      steps[steps.size()-1].dot.row_last   = 1'b1;
   endfunction

   // receiver: random ready, or a long counted hold-off when asked
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_trigger != stall_seen) begin
         stall_seen = stall_trigger;
         stall_left = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   // every accepted result transaction is matched against the oldest expectation
   always @(posedge clock) begin : check_dots
      imm_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_dots.size() == 0) begin
            report_mismatch($sformatf("unexpected result: column %0d sum %0d last %0b",
                                      rsp_data.out_column, rsp_data.dot_sum,
                                      rsp_data.row_last));
         end else begin
            want = expected_dots.pop_front();
            if (rsp_data.out_column !== want.out_column)
               report_mismatch($sformatf("out_column %0d, expected %0d",
                                         rsp_data.out_column, want.out_column));
            if (rsp_data.dot_sum !== want.dot_sum)
               report_mismatch($sformatf("dot_sum %0d, expected %0d (column %0d)",
                                         rsp_data.dot_sum, want.dot_sum, want.out_column));
            if (rsp_data.row_last !== want.row_last)
               report_mismatch($sformatf("row_last %0b, expected %0b (column %0d)",
                                         rsp_data.row_last, want.row_last,
                                         want.out_column));
         end
      end
   end

   initial begin : stimulus
      imm_pkg::req_type item;
      int               k_pick;
      int               c_pick;
      int               pick;

      shadow_fill  = '0;
      shadow_k     = imm_pkg::K_LEN_RST;
      shadow_c     = imm_pkg::C_LEN_RST;
      // sender mostly busy, receiver mostly idle
      req_idle_pct = 18;
      rsp_idle_pct = 79;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // load the leading weights of every column, so no row reads an unwritten entry
      for (int c = 0; c < COLS; c++) begin
         for (int p = 0; p < PRELOAD_LEN; p++) begin
            item.kind     = imm_pkg::KIND_WEIGHT;
            item.column   = imm_pkg::COL_W'(c);
            item.position = imm_pkg::POS_W'(p);
            item.value    = imm_pkg::VAL_W'($urandom());
            send_req(item);
         end
      end

      // directed table: single-element rows at the value extremes
      add_cfg(imm_pkg::CSR_K_LEN, 1);
      add_cfg(imm_pkg::CSR_C_LEN, 1);
      add_item(imm_pkg::KIND_WEIGHT, 0, 0, -128);
      add_typed(-128, 16384);
      add_typed(127, -16256);
      add_item(imm_pkg::KIND_WEIGHT, 0, 0, 127);
      add_typed(127, 16129);
      add_typed(-128, -16256);
      add_typed(0, 0);
      // zero column count behaves as one column
      add_cfg(imm_pkg::CSR_C_LEN, 0);
      add_typed(-1, -127);
      // zero length behaves as one element
      add_cfg(imm_pkg::CSR_K_LEN, 0);
      add_item(imm_pkg::KIND_WEIGHT, 0, 0, -1);
      add_typed(-128, 128);
      // column count above the limit saturates to sixteen
      add_cfg(imm_pkg::CSR_C_LEN, C_MAX_CODE);
      add_cfg(imm_pkg::CSR_K_LEN, 1);
      add_item(imm_pkg::KIND_ACT, 0, 0, 1);
      // length lowered while a row is partly filled
      add_cfg(imm_pkg::CSR_C_LEN, COLS);
      add_cfg(imm_pkg::CSR_K_LEN, 4);
      add_item(imm_pkg::KIND_ACT, 0, 0, -128);
      add_item(imm_pkg::KIND_ACT, 0, 0, 127);
      add_item(imm_pkg::KIND_ACT, 0, 0, -1);
      add_cfg(imm_pkg::CSR_K_LEN, 2);
      add_item(imm_pkg::KIND_ACT, 0, 0, 77);
      // three-element row with the largest products
      add_cfg(imm_pkg::CSR_C_LEN, 1);
      add_cfg(imm_pkg::CSR_K_LEN, 3);
      add_item(imm_pkg::KIND_WEIGHT, 0, 0, 127);
      add_item(imm_pkg::KIND_WEIGHT, 0, 1, -128);
      add_item(imm_pkg::KIND_WEIGHT, 0, 2, 127);
      add_item(imm_pkg::KIND_ACT, 0, 0, 127);
      add_item(imm_pkg::KIND_ACT, 0, 0, -128);
      add_typed(127, 48642);
      // highest weight address
      add_cfg(imm_pkg::CSR_C_LEN, 2);
      add_cfg(imm_pkg::CSR_K_LEN, 1);
      add_item(imm_pkg::KIND_WEIGHT, COLS - 1, DEPTH - 1, -128);
      add_item(imm_pkg::KIND_ACT, 0, 0, -128);

      foreach (steps[i]) begin
         if (steps[i].op == STEP_CFG) csr_write(steps[i].index, steps[i].wdata);
         else send_req(steps[i].item, steps[i].typed, steps[i].dot);
      end

      // random phases, each under its own register settings; the fill count
      // carries across phase boundaries, so length changes land mid-row too
      for (int p = 0; p < NUM_PHASES; p++) begin
         if (p == 3) begin
            req_idle_pct = 79;
            rsp_idle_pct = 18;
         end else if (p == 6) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end

         pick = $urandom_range(0, 9);
         if (p == HOLD_PHASE) k_pick = 1;
         else if (pick == 0) k_pick = 0;
         else if (pick == 1) k_pick = $urandom_range(9, PRELOAD_LEN);
         else k_pick = $urandom_range(1, 8);

         pick = $urandom_range(0, 9);
         if (p == HOLD_PHASE) c_pick = COLS;
         else if (pick == 0) c_pick = 0;
         else if (pick == 1) c_pick = $urandom_range(COLS + 1, C_MAX_CODE);
         else if (pick == 2) c_pick = COLS;
         else c_pick = $urandom_range(1, 8);

         csr_write(imm_pkg::CSR_K_LEN, imm_pkg::CSR_DATA_W'(k_pick));
         csr_write(imm_pkg::CSR_C_LEN, imm_pkg::CSR_DATA_W'(c_pick));

         // every activation closes a sixteen-column row while the receiver holds off,
         // so the output backs up and the block stalls its request side
         if (p == HOLD_PHASE) stall_trigger++;

         for (int i = 0; i < PHASE_ITEMS; i++) begin
            item = random_req(25);
            send_req(item);
         end
      end

      req_valid <= 1'b0;
      for (int n = 0; n < DRAIN_LIMIT && expected_dots.size() > 0; n++) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_dots.size() > 0)
         report_mismatch($sformatf("%0d expected results never arrived",
                                   expected_dots.size()));
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // watchdog for a hung handshake
   initial begin
      #(TIMEOUT_NS);
      $display("Simulation FAILED");
      $finish;
   end

endmodule
